// ===== hdl/ihx_enc_pkg.sv =====
// Package for the Intel HEX record encoder.
// Holds the state and record-type enums, the controller/datapath structs and the hex digit function.
// Has no dependencies.
package ihx_enc_pkg;

    localparam int FILL_W = 6;
    localparam int IDX_W  = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_BODY,
        ST_SUM
    } t_state;

    typedef enum logic [7:0] {
        KIND_DATA = 8'h00,
        KIND_EOF  = 8'h01,
        KIND_EXT  = 8'h04
    } t_kind;

    localparam logic [1:0] HDR_LEN     = 2'd0;
    localparam logic [1:0] HDR_ADDR_HI = 2'd1;
    localparam logic [1:0] HDR_ADDR_LO = 2'd2;
    localparam logic [1:0] HDR_TYPE    = 2'd3;

    localparam logic [7:0] EXT_LEN = 8'h02;

    typedef struct packed {
        logic              accept;
        logic              advance;
        t_state            phase;
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  rd_idx;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic              finish;
        logic              need_ext;
        logic              closes;
        logic              flush_nonempty;
        logic              out_free;
        logic [FILL_W-1:0] data_len;
    } t_status;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = 7'd48 + {3'b000, nib};
        end else begin
            hex_char = 7'd55 + {3'b000, nib};
        end
    endfunction

endpackage

// ===== hdl/ihx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ihx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ihx_ctrl.sv =====
// Controller for the Intel HEX record encoder: sequences the records and their bytes.
// Depends on ihx_enc_pkg.
module ihx_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  ihx_enc_pkg::t_status i_status,
    output ihx_enc_pkg::t_cmd    o_cmd
);

    ihx_enc_pkg::t_state                r_state, n_state;
    ihx_enc_pkg::t_kind                 r_kind, n_kind;
    logic [ihx_enc_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                               r_pend_data, n_pend_data;
    logic                               r_pend_eof, n_pend_eof;

    logic accept;
    logic advance;
    logic body_last;

    assign accept  = i_valid && (r_state == ihx_enc_pkg::ST_IDLE);
    assign advance = (r_state != ihx_enc_pkg::ST_IDLE) && i_status.out_free;

    always_comb begin
        if (r_kind == ihx_enc_pkg::KIND_EXT) begin
            body_last = (r_idx == ihx_enc_pkg::IDX_W'(1));
        end else begin
            body_last = ({1'b0, r_idx} + ihx_enc_pkg::FILL_W'(1)) == i_status.data_len;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_pend_data = r_pend_data;
        n_pend_eof  = r_pend_eof;
        unique case (r_state)
            ihx_enc_pkg::ST_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    priority if (i_status.finish) begin
                        n_state = ihx_enc_pkg::ST_HEAD;
                        if (i_status.flush_nonempty) begin
                            n_kind     = ihx_enc_pkg::KIND_DATA;
                            n_pend_eof = 1'b1;
                        end else begin
                            n_kind = ihx_enc_pkg::KIND_EOF;
                        end
                    end else if (i_status.need_ext) begin
                        n_state     = ihx_enc_pkg::ST_HEAD;
                        n_kind      = ihx_enc_pkg::KIND_EXT;
                        n_pend_data = i_status.closes;
                    end else if (i_status.closes) begin
                        n_state = ihx_enc_pkg::ST_HEAD;
                        n_kind  = ihx_enc_pkg::KIND_DATA;
                    end else begin
                        n_state = r_state;
                    end
                end
            end
            ihx_enc_pkg::ST_HEAD: begin
                if (advance) begin
                    if (r_idx[1:0] == ihx_enc_pkg::HDR_TYPE) begin
                        n_idx   = '0;
                        n_state = (r_kind == ihx_enc_pkg::KIND_EOF) ?
                                  ihx_enc_pkg::ST_SUM : ihx_enc_pkg::ST_BODY;
                    end else begin
                        n_idx = r_idx + ihx_enc_pkg::IDX_W'(1);
                    end
                end
            end
            ihx_enc_pkg::ST_BODY: begin
                if (advance) begin
                    if (body_last) begin
                        n_idx   = '0;
                        n_state = ihx_enc_pkg::ST_SUM;
                    end else begin
                        n_idx = r_idx + ihx_enc_pkg::IDX_W'(1);
                    end
                end
            end
            ihx_enc_pkg::ST_SUM: begin
                if (advance) begin
                    n_idx = '0;
                    priority if (r_pend_data) begin
                        n_kind      = ihx_enc_pkg::KIND_DATA;
                        n_pend_data = 1'b0;
                        n_state     = ihx_enc_pkg::ST_HEAD;
                    end else if (r_pend_eof) begin
                        n_kind     = ihx_enc_pkg::KIND_EOF;
                        n_pend_eof = 1'b0;
                        n_state    = ihx_enc_pkg::ST_HEAD;
                    end else begin
                        n_state = ihx_enc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ihx_enc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ihx_enc_pkg::ST_IDLE;
            r_kind      <= ihx_enc_pkg::KIND_DATA;
            r_idx       <= '0;
            r_pend_data <= 1'b0;
            r_pend_eof  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_idx       <= n_idx;
            r_pend_data <= n_pend_data;
            r_pend_eof  <= n_pend_eof;
        end
    end

    always_comb begin
        o_stall        = (r_state != ihx_enc_pkg::ST_IDLE);
        o_cmd.accept   = accept;
        o_cmd.advance  = advance;
        o_cmd.phase    = r_state;
        o_cmd.kind     = r_kind;
        o_cmd.idx      = r_idx;
        o_cmd.last     = (r_state == ihx_enc_pkg::ST_SUM) && !r_pend_data && !r_pend_eof;
        o_cmd.rd_idx   = '0;
        if (r_state == ihx_enc_pkg::ST_BODY) begin
            o_cmd.rd_idx = (advance && !body_last) ? r_idx + ihx_enc_pkg::IDX_W'(1) : r_idx;
        end
    end

endmodule

// ===== hdl/ihx_dp.sv =====
// Datapath for the Intel HEX record encoder: record buffer, address state, checksum, output stage.
// Depends on ihx_enc_pkg and ihx_ram.
module ihx_dp #(
    parameter int REC_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ihx_enc_pkg::t_cmd    i_cmd,
    output ihx_enc_pkg::t_status o_status,
    input  logic                 i_req_type,
    input  logic [31:0]          i_byte_addr,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_segment_end,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_record_byte,
    output logic [6:0]           o_hex_high_char,
    output logic [6:0]           o_hex_low_char,
    output logic                 o_record_start,
    output logic                 o_record_end,
    output logic                 o_last_of_run
);

    localparam int AW = (REC_BYTES > 1) ? $clog2(REC_BYTES) : 1;

    logic [ihx_enc_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [ihx_enc_pkg::FILL_W-1:0] r_len, n_len;
    logic [15:0]                    r_low_addr, n_low_addr;
    logic [15:0]                    r_upper, n_upper;
    logic [7:0]                     r_sum, n_sum;

    logic                           r_valid;
    logic [7:0]                     r_byte;
    logic                           r_start;
    logic                           r_end;
    logic                           r_last;

    logic [ihx_enc_pkg::FILL_W-1:0] fill_inc;
    logic                           is_data;
    logic                           wr_en;
    logic [7:0]                     rd_data;
    logic [7:0]                     rec_len;
    logic [7:0]                     cur_byte;
    logic                           cur_start;
    logic                           cur_end;

    assign is_data  = (i_req_type == 1'b0);
    assign fill_inc = r_fill + ihx_enc_pkg::FILL_W'(1);
    assign wr_en    = i_cmd.accept && is_data;

    ihx_ram #(
        .WIDTH (8),
        .DEPTH (REC_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_data_byte),
        .i_rd_addr (i_cmd.rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        o_status.finish         = !is_data;
        o_status.need_ext       = is_data && (r_fill == '0) && (i_byte_addr[31:16] != r_upper);
        o_status.closes         = is_data &&
                                  (i_segment_end ||
                                   fill_inc == ihx_enc_pkg::FILL_W'(REC_BYTES));
        o_status.flush_nonempty = !is_data && (r_fill != '0);
        o_status.out_free       = !r_valid || !i_stall;
        o_status.data_len       = r_len;
    end

    always_comb begin
        n_fill     = r_fill;
        n_len      = r_len;
        n_low_addr = r_low_addr;
        n_upper    = r_upper;
        if (i_cmd.accept) begin
            if (!is_data) begin
                n_len  = r_fill;
                n_fill = '0;
            end else begin
                if (r_fill == '0) begin
                    n_low_addr = i_byte_addr[15:0];
                    n_upper    = i_byte_addr[31:16];
                end
                if (o_status.closes) begin
                    n_len  = fill_inc;
                    n_fill = '0;
                end else begin
                    n_fill = fill_inc;
                end
            end
        end
    end

    always_comb begin
        unique case (i_cmd.kind)
            ihx_enc_pkg::KIND_EXT:  rec_len = ihx_enc_pkg::EXT_LEN;
            ihx_enc_pkg::KIND_DATA: rec_len = {2'b00, r_len};
            default:                rec_len = 8'h00;
        endcase

        cur_byte  = 8'h00;
        cur_start = 1'b0;
        cur_end   = 1'b0;
        unique case (i_cmd.phase)
            ihx_enc_pkg::ST_HEAD: begin
                unique case (i_cmd.idx[1:0])
                    ihx_enc_pkg::HDR_LEN: begin
                        cur_byte  = rec_len;
                        cur_start = 1'b1;
                    end
                    ihx_enc_pkg::HDR_ADDR_HI: begin
                        cur_byte = (i_cmd.kind == ihx_enc_pkg::KIND_DATA) ?
                                   r_low_addr[15:8] : 8'h00;
                    end
                    ihx_enc_pkg::HDR_ADDR_LO: begin
                        cur_byte = (i_cmd.kind == ihx_enc_pkg::KIND_DATA) ?
                                   r_low_addr[7:0] : 8'h00;
                    end
                    default: begin
                        cur_byte = 8'(i_cmd.kind);
                    end
                endcase
            end
            ihx_enc_pkg::ST_BODY: begin
                if (i_cmd.kind == ihx_enc_pkg::KIND_EXT) begin
                    cur_byte = (i_cmd.idx == '0) ? r_upper[15:8] : r_upper[7:0];
                end else begin
                    cur_byte = rd_data;
                end
            end
            ihx_enc_pkg::ST_SUM: begin
                cur_byte = 8'h00 - r_sum;
                cur_end  = 1'b1;
            end
            default: begin
                cur_byte = 8'h00;
            end
        endcase

        n_sum = r_sum;
        if (i_cmd.advance) begin
            n_sum = cur_start ? cur_byte : r_sum + cur_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_len      <= '0;
            r_low_addr <= '0;
            r_upper    <= '0;
            r_sum      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_len      <= n_len;
            r_low_addr <= n_low_addr;
            r_upper    <= n_upper;
            r_sum      <= n_sum;
            if (i_cmd.advance) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_byte  <= cur_byte;
            r_start <= cur_start;
            r_end   <= cur_end;
            r_last  <= i_cmd.last;
        end
    end

    assign o_valid         = r_valid;
    assign o_record_byte   = r_byte;
    assign o_hex_high_char = ihx_enc_pkg::hex_char(r_byte[7:4]);
    assign o_hex_low_char  = ihx_enc_pkg::hex_char(r_byte[3:0]);
    assign o_record_start  = r_start;
    assign o_record_end    = r_end;
    assign o_last_of_run   = r_last;

endmodule

// ===== hdl/intel_hex_record_encoder.sv =====
// Intel HEX record encoder, top level: joins the controller and the datapath.
// Depends on ihx_enc_pkg, ihx_ctrl, ihx_dp and ihx_ram.
// An item that causes no record is taken with no stall. Otherwise the input stays stalled
// while its records go out, one byte per cycle unless the output stalls; the first byte is
// registered once the header state is entered. Bytes: 7 for an extended address record,
// 5 + N for N data bytes, 5 for end of file. Synchronous reset; no buffer clearing pass.
module intel_hex_record_encoder #(
    parameter int REC_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_byte_addr,
    input  logic [7:0]  i_data_byte,
    input  logic        i_segment_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_record_byte,
    output logic [6:0]  o_hex_high_char,
    output logic [6:0]  o_hex_low_char,
    output logic        o_record_start,
    output logic        o_record_end,
    output logic        o_last_of_run
);

    ihx_enc_pkg::t_cmd    cmd;
    ihx_enc_pkg::t_status status;

    ihx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ihx_dp #(
        .REC_BYTES (REC_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (i_req_type),
        .i_byte_addr     (i_byte_addr),
        .i_data_byte     (i_data_byte),
        .i_segment_end   (i_segment_end),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_record_byte   (o_record_byte),
        .o_hex_high_char (o_hex_high_char),
        .o_hex_low_char  (o_hex_low_char),
        .o_record_start  (o_record_start),
        .o_record_end    (o_record_end),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
